// ===== hdl/e2r_pkg.sv =====
// Shared types, constants and helpers for the Euler angle to rotation matrix block.
// Used by the CORDIC cells, the matrix product stage and the top level.
`timescale 1ns / 1ps
package e2r_pkg;

  localparam int LaneW = 34;
  localparam int TrigW = 24;
  localparam int ProdW = 48;
  localparam int WideW = 72;

  localparam logic signed [LaneW-1:0] Q30Pi     = 34'sd3373259426;
  localparam logic signed [LaneW-1:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [LaneW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [WideW-1:0] OneQ14     = 72'sd16384;

  typedef struct packed {
    logic signed [LaneW-1:0] x;
    logic signed [LaneW-1:0] y;
    logic signed [LaneW-1:0] z;
    logic                    neg;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  function automatic logic signed [LaneW-1:0] atan_q30(input logic [4:0] i);
    logic signed [LaneW-1:0] a;
    case (i)
      5'd0:  a = 34'sh03243F6A8;
      5'd1:  a = 34'sh01DAC6705;
      5'd2:  a = 34'sh00FADBAFC;
      5'd3:  a = 34'sh007F56EA6;
      5'd4:  a = 34'sh003FEAB76;
      5'd5:  a = 34'sh001FFD55B;
      5'd6:  a = 34'sh000FFFAAA;
      5'd7:  a = 34'sh0007FFF55;
      5'd8:  a = 34'sh0003FFFEA;
      5'd9:  a = 34'sh0001FFFFD;
      5'd10: a = 34'sh0000FFFFF;
      5'd11: a = 34'sh00007FFFF;
      5'd12: a = 34'sh00003FFFF;
      5'd13: a = 34'sh00001FFFF;
      5'd14: a = 34'sh00000FFFF;
      5'd15: a = 34'sh000007FFF;
      5'd16: a = 34'sh000003FFF;
      5'd17: a = 34'sh000001FFF;
      5'd18: a = 34'sh000000FFF;
      5'd19: a = 34'sh0000007FF;
      5'd20: a = 34'sh0000003FF;
      5'd21: a = 34'sh0000001FF;
      5'd22: a = 34'sh0000000FF;
      5'd23: a = 34'sh00000007F;
      5'd24: a = 34'sh00000003F;
      5'd25: a = 34'sh00000001F;
      5'd26: a = 34'sh00000000F;
      5'd27: a = 34'sh000000008;
      5'd28: a = 34'sh000000004;
      5'd29: a = 34'sh000000002;
      5'd30: a = 34'sh000000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Round half up by sh bits, then clamp to plus or minus one in Q2.14.
  function automatic logic signed [15:0] rnd_clamp(input logic signed [WideW-1:0] v,
                                                   input int sh);
    logic signed [WideW-1:0] r;
    r = (v + (72'sd1 <<< (sh - 1))) >>> sh;
    if (r > OneQ14) r = OneQ14;
    if (r < -OneQ14) r = -OneQ14;
    return r[15:0];
  endfunction

endpackage

// ===== hdl/e2r_cordic_cell.sv =====
// One CORDIC rotation stage for the three angle lanes, registered.
// Depends on e2r_pkg for the lane type and the arctangent table.
`timescale 1ns / 1ps
module e2r_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  e2r_pkg::lanes_t lanes_in,
  output logic            vld_out,
  output e2r_pkg::lanes_t lanes_out
);
  import e2r_pkg::*;

  localparam logic signed [LaneW-1:0] Da = atan_q30(5'(STAGE));

  lanes_t lanes_nxt;
  lanes_t lanes_r;
  logic   vld_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lanes_nxt[k].neg = lanes_in[k].neg;
      if (!lanes_in[k].z[LaneW-1]) begin
        lanes_nxt[k].x = lanes_in[k].x - (lanes_in[k].y >>> STAGE);
        lanes_nxt[k].y = lanes_in[k].y + (lanes_in[k].x >>> STAGE);
        lanes_nxt[k].z = lanes_in[k].z - Da;
      end else begin
        lanes_nxt[k].x = lanes_in[k].x + (lanes_in[k].y >>> STAGE);
        lanes_nxt[k].y = lanes_in[k].y - (lanes_in[k].x >>> STAGE);
        lanes_nxt[k].z = lanes_in[k].z + Da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign vld_out   = vld_r;
  assign lanes_out = lanes_r;

endmodule

// ===== hdl/e2r_dcm.sv =====
// Sine/cosine rounding and the ZYX matrix product, four registered stages.
// Depends on e2r_pkg; fed by the last CORDIC cell.
`timescale 1ns / 1ps
module e2r_dcm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  e2r_pkg::lanes_t lanes_in,
  output logic            vld_out,
  output logic [143:0]    mat_out
);
  import e2r_pkg::*;

  logic [3:0] vld_r;

  // stage 1: sine and cosine in Q20, lane 0 roll, 1 pitch, 2 yaw
  logic signed [TrigW-1:0] s_r [3];
  logic signed [TrigW-1:0] c_r [3];
  // stage 2: pair products in Q40
  logic signed [ProdW-1:0] cycp_r, sycp_r, cpsr_r, cpcr_r, cysp_r, sysp_r;
  logic signed [ProdW-1:0] sycr_r, sysr_r, cycr_r, cysr_r;
  logic signed [TrigW-1:0] sr2_r, cr2_r, sp2_r;
  // stage 3: triple products in Q60
  logic signed [WideW-1:0] t1_r, t2_r, t3_r, t4_r;
  logic signed [ProdW-1:0] cycp3_r, sycp3_r, cpsr3_r, cpcr3_r;
  logic signed [ProdW-1:0] sycr3_r, sysr3_r, cycr3_r, cysr3_r;
  logic signed [TrigW-1:0] sp3_r;
  logic [143:0] mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [LaneW-1:0] xs;
    logic signed [LaneW-1:0] ys;
    logic signed [LaneW+1:0] xr;
    logic signed [LaneW+1:0] yr;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        xs = lanes_in[k].neg ? -lanes_in[k].x : lanes_in[k].x;
        ys = lanes_in[k].neg ? -lanes_in[k].y : lanes_in[k].y;
        xr = (36'(xs) + 36'sd512) >>> 10;
        yr = (36'(ys) + 36'sd512) >>> 10;
        c_r[k] <= xr[TrigW-1:0];
        s_r[k] <= yr[TrigW-1:0];
      end

      cycp_r <= ProdW'(c_r[2]) * ProdW'(c_r[1]);
      sycp_r <= ProdW'(s_r[2]) * ProdW'(c_r[1]);
      cpsr_r <= ProdW'(c_r[1]) * ProdW'(s_r[0]);
      cpcr_r <= ProdW'(c_r[1]) * ProdW'(c_r[0]);
      cysp_r <= ProdW'(c_r[2]) * ProdW'(s_r[1]);
      sysp_r <= ProdW'(s_r[2]) * ProdW'(s_r[1]);
      sycr_r <= ProdW'(s_r[2]) * ProdW'(c_r[0]);
      sysr_r <= ProdW'(s_r[2]) * ProdW'(s_r[0]);
      cycr_r <= ProdW'(c_r[2]) * ProdW'(c_r[0]);
      cysr_r <= ProdW'(c_r[2]) * ProdW'(s_r[0]);
      sr2_r  <= s_r[0];
      cr2_r  <= c_r[0];
      sp2_r  <= s_r[1];

      t1_r    <= WideW'(cysp_r) * WideW'(sr2_r);
      t2_r    <= WideW'(cysp_r) * WideW'(cr2_r);
      t3_r    <= WideW'(sysp_r) * WideW'(sr2_r);
      t4_r    <= WideW'(sysp_r) * WideW'(cr2_r);
      cycp3_r <= cycp_r;
      sycp3_r <= sycp_r;
      cpsr3_r <= cpsr_r;
      cpcr3_r <= cpcr_r;
      sycr3_r <= sycr_r;
      sysr3_r <= sysr_r;
      cycr3_r <= cycr_r;
      cysr3_r <= cysr_r;
      sp3_r   <= sp2_r;

      mat_r[15:0]    <= rnd_clamp(WideW'(cycp3_r), 26);
      mat_r[31:16]   <= rnd_clamp(t1_r - (WideW'(sycr3_r) <<< 20), 46);
      mat_r[47:32]   <= rnd_clamp(t2_r + (WideW'(sysr3_r) <<< 20), 46);
      mat_r[63:48]   <= rnd_clamp(WideW'(sycp3_r), 26);
      mat_r[79:64]   <= rnd_clamp(t3_r + (WideW'(cycr3_r) <<< 20), 46);
      mat_r[95:80]   <= rnd_clamp(t4_r - (WideW'(cysr3_r) <<< 20), 46);
      mat_r[111:96]  <= rnd_clamp(-WideW'(sp3_r), 6);
      mat_r[127:112] <= rnd_clamp(WideW'(cpsr3_r), 26);
      mat_r[143:128] <= rnd_clamp(WideW'(cpcr3_r), 26);
    end
  end

  assign vld_out = vld_r[3];
  assign mat_out = mat_r;

endmodule

// ===== hdl/euler_to_rotation_matrix.sv =====
// Top level: ZYX Euler angles to direction cosine matrix.
// Depends on e2r_pkg, e2r_cordic_cell and e2r_dcm.
//
// Input channel in_*: one transfer carries roll, pitch and yaw in signed
// Q3.(ANGLE_WIDTH-3). Result channel out_*: one transfer carries the nine
// matrix elements of Rz(yaw)*Ry(pitch)*Rx(roll) in signed Q2.14, clamped
// to plus or minus one. Each input transfer gives exactly one result.
// The path holds TRIG_STAGES + 5 register stages: one angle reduction
// register, one chained CORDIC cell per stage, then rounding, two
// multiplier stages and the summing output register.
// Throughput is one item per clock unless the receiver stalls; the chain of
// CORDIC cells and the registered multipliers set the latency, not the rate.
// Reset clears all valid flags; nothing is in flight afterwards.
// When the receiver stalls, the whole chain holds and in_tready drops in
// the same cycle; it rises again as soon as the held result is taken.
`timescale 1ns / 1ps
module euler_to_rotation_matrix #(
  parameter int ANGLE_WIDTH = 16,
  parameter int TRIG_STAGES = 16,
  localparam int InW = ((3 * ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  // roll_angle, pitch_angle, yaw_angle, zero fill
  input  logic [InW-1:0] in_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  // m_row0_col0 .. m_row0_col2, m_row1_col0 .. m_row1_col2, m_row2_col0 .. m_row2_col2
  output logic [143:0]   out_tdata
);
  import e2r_pkg::*;

  localparam int Sh = 33 - ANGLE_WIDTH;

  logic   en;
  lanes_t lanes0_nxt;
  lanes_t lanes0_r;
  logic   vld0_r;
  lanes_t chain_lanes [TRIG_STAGES+1];
  logic   chain_vld   [TRIG_STAGES+1];

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [LaneW-1:0] z;
      z = LaneW'($signed(in_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH])) <<< Sh;
      lanes0_nxt[k].x   = CordicGain;
      lanes0_nxt[k].y   = '0;
      lanes0_nxt[k].neg = 1'b0;
      // fold into minus half pi .. half pi, flip the result later
      if (z > Q30HalfPi) begin
        z = z - Q30Pi;
        lanes0_nxt[k].neg = 1'b1;
      end else if (z < -Q30HalfPi) begin
        z = z + Q30Pi;
        lanes0_nxt[k].neg = 1'b1;
      end
      lanes0_nxt[k].z = z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes0_r <= lanes0_nxt;
    end
  end

  assign chain_lanes[0] = lanes0_r;
  assign chain_vld[0]   = vld0_r;

  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
    e2r_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .vld_in   (chain_vld[g]),
      .lanes_in (chain_lanes[g]),
      .vld_out  (chain_vld[g+1]),
      .lanes_out(chain_lanes[g+1])
    );
  end

  e2r_dcm u_dcm (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (chain_vld[TRIG_STAGES]),
    .lanes_in(chain_lanes[TRIG_STAGES]),
    .vld_out (out_tvalid),
    .mat_out (out_tdata)
  );

  a_clamp_00: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384 &&
                    $signed(out_tdata[15:0]) >= -16'sd16384))
    else $error("element 0,0 outside clamp");

  a_clamp_20: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[111:96]) <= 16'sd16384 &&
                    $signed(out_tdata[111:96]) >= -16'sd16384))
    else $error("element 2,0 outside clamp");

  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(chain_vld[0])))
    else $error("chain moved while output stalled");

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
